FILE: rtl/core/median_and_abs_deviation_sum_defines.svh
// Assertion macros shared by the median and deviation-sum block.
`ifndef MEDIAN_AND_ABS_DEVIATION_SUM_DEFINES_SVH
`define MEDIAN_AND_ABS_DEVIATION_SUM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MADS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MADS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/mads_pkg.sv
// Package with shared types and constants of the median and deviation-sum block.
package mads_pkg;

  localparam int unsigned MAX_COUNT_DEF   = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 16;
  localparam int unsigned TOTAL_W         = 21;
  localparam int unsigned SIZE_W          = 7;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_SWEEP,
    ST_DONE
  } mads_state_e;

  typedef struct packed {
    logic insert;
    logic load;
    logic step;
    logic publish;
  } mads_cmd_t;

  typedef struct packed {
    logic last_step;
  } mads_status_t;

endpackage

FILE: rtl/core/mads_ctrl.sv
// Controller state machine of the median and deviation-sum block.
module mads_ctrl
  import mads_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         set_end_i,
  input  logic         out_ready_i,
  input  mads_status_t status_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  output mads_cmd_t    cmd_o,
  output mads_state_e  state_o
);

  mads_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        publish;

  assign accept  = (state_q == ST_FILL) && in_valid_i;
  assign publish = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL: begin
        if (accept && set_end_i) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (status_i.last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (publish) begin
          state_d = ST_FILL;
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_comb begin
    cmd_o.insert  = accept;
    cmd_o.load    = accept && set_end_i;
    cmd_o.step    = (state_q == ST_SWEEP);
    cmd_o.publish = publish;
    in_ready_o    = (state_q == ST_FILL);
    out_valid_o   = out_valid_q;
    state_o       = state_q;
    if (publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/core/mads_datapath.sv
// Datapath: sorted insertion chain, deviation-sum sweep and result register.
module mads_datapath
  import mads_pkg::*;
#(
  parameter int unsigned MAX_COUNT   = MAX_COUNT_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mads_cmd_t                     cmd_i,
  input  logic signed [VALUE_WIDTH-1:0] sample_value_i,
  output mads_status_t                  status_o,
  output logic signed [VALUE_WIDTH-1:0] median_value_o,
  output logic        [TOTAL_W-1:0]     distance_total_o,
  output logic        [SIZE_W-1:0]      set_size_o,
  output logic                          overflow_flag_o
);

  localparam int unsigned CW    = $clog2(MAX_COUNT + 1);
  localparam int unsigned EXT_W = (TOTAL_W > VALUE_WIDTH) ? TOTAL_W : VALUE_WIDTH;

  logic signed [VALUE_WIDTH-1:0] cell_q [MAX_COUNT];
  logic signed [VALUE_WIDTH-1:0] cell_d [MAX_COUNT];
  logic        [MAX_COUNT-1:0]   gt;
  logic        [MAX_COUNT-1:0]   vacant;

  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  logic          full;
  logic [CW-1:0] n_new;

  logic [CW-1:0]      size_q, half_q, upper_q, mid_q, k_q;
  logic               flag_q;
  logic [TOTAL_W-1:0] acc_q, acc_d;
  logic signed [VALUE_WIDTH-1:0] med_q;
  logic signed [EXT_W-1:0]       head_ext;
  logic [TOTAL_W-1:0]            term;

  logic signed [VALUE_WIDTH-1:0] out_med_q;
  logic [TOTAL_W-1:0]            out_total_q;
  logic [CW-1:0]                 out_size_q;
  logic                          out_flag_q;

  assign full  = (count_q == CW'(MAX_COUNT));
  assign n_new = full ? count_q : count_q + CW'(1);

  // Each cell compares its value with the incoming sample.
  always_comb begin
    for (int i = 0; i < MAX_COUNT; i++) begin
      vacant[i] = (CW'(i) >= count_q);
      gt[i]     = !vacant[i] && (cell_q[i] > sample_value_i);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_COUNT; i++) begin
      cell_d[i] = cell_q[i];
    end
    if (cmd_i.step) begin
      for (int i = 0; i < MAX_COUNT - 1; i++) begin
        cell_d[i] = cell_q[i + 1];
      end
    end else if (cmd_i.insert && !full) begin
      for (int i = 0; i < MAX_COUNT; i++) begin
        if (gt[i] || vacant[i]) begin
          cell_d[i] = sample_value_i;
        end
      end
      for (int i = 1; i < MAX_COUNT; i++) begin
        if ((gt[i] || vacant[i]) && gt[i - 1]) begin
          cell_d[i] = cell_q[i - 1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_COUNT; i++) begin
      cell_q[i] <= cell_d[i];
    end
  end

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (cmd_i.load) begin
      count_d   = '0;
      dropped_d = 1'b0;
    end else if (cmd_i.insert) begin
      if (full) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      dropped_q <= 1'b0;
      k_q       <= '0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
      if (cmd_i.load) begin
        k_q <= '0;
      end else if (cmd_i.step) begin
        k_q <= k_q + CW'(1);
      end
    end
  end

  // The head cell holds sorted element k during sweep step k.
  assign head_ext = EXT_W'(cell_q[0]);
  assign term     = head_ext[TOTAL_W-1:0];

  always_comb begin
    acc_d = acc_q;
    if (k_q >= upper_q) begin
      acc_d = acc_d + term;
    end
    if (k_q < half_q) begin
      acc_d = acc_d - term;
    end
  end

  assign status_o.last_step = (k_q == size_q - CW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      size_q  <= n_new;
      flag_q  <= dropped_q | full;
      half_q  <= n_new >> 1;
      upper_q <= n_new - (n_new >> 1);
      mid_q   <= (n_new - CW'(1)) >> 1;
      acc_q   <= '0;
    end else if (cmd_i.step) begin
      acc_q <= acc_d;
      if (k_q == mid_q) begin
        med_q <= cell_q[0];
      end
    end
    if (cmd_i.publish) begin
      out_med_q   <= med_q;
      out_total_q <= acc_q;
      out_size_q  <= size_q;
      out_flag_q  <= flag_q;
    end
  end

  assign median_value_o   = out_med_q;
  assign distance_total_o = out_total_q;
  assign set_size_o       = SIZE_W'(out_size_q);
  assign overflow_flag_o  = out_flag_q;

endmodule

FILE: rtl/core/median_and_abs_deviation_sum.sv
// A value without the set end mark is stored in the sorted chain; values stream at one per cycle in the fill phase.
// The last value of a set starts the sweep, and its result follows once the sweep is done.
// The input is held off during the sweep and result phases; the sweep takes one element per cycle.
// The output register lets the next set fill while a finished result still waits.
// Reset is asynchronous, active low; it clears the count, the dropped-value flag, the sweep index and the controller.
// Stored values need no clearing, as only entries below the count are ever used.
`include "median_and_abs_deviation_sum_defines.svh"

// Top level of the lower median and sum of absolute deviations block.
module median_and_abs_deviation_sum
  import mads_pkg::*;
#(
  parameter int unsigned MAX_COUNT   = MAX_COUNT_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] sample_value_i,
  input  logic                          set_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [VALUE_WIDTH-1:0] median_value_o,
  output logic        [TOTAL_W-1:0]     distance_total_o,
  output logic        [SIZE_W-1:0]      set_size_o,
  output logic                          overflow_flag_o
);

  // The controller sequences three phases: filling the sorted chain one
  // transaction per cycle, sweeping the chain once to form the median and
  // the deviation sum, and handing the result to the output register.
  mads_cmd_t    cmd;
  mads_status_t status;
  mads_state_e  state;

  mads_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .set_end_i   (set_end_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .state_o     (state)
  );

  // The datapath keeps the set in a chain of cells in ascending order. Each
  // cell compares itself with the new value, so all cells update at once on
  // an insertion. During the sweep the chain shifts toward its head, where
  // the lower half is subtracted and the upper half added; that equals the
  // total of the pair differences taken inward from both ends.
  mads_datapath #(
    .MAX_COUNT   (MAX_COUNT),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sample_value_i   (sample_value_i),
    .status_o         (status),
    .median_value_o   (median_value_o),
    .distance_total_o (distance_total_o),
    .set_size_o       (set_size_o),
    .overflow_flag_o  (overflow_flag_o)
  );

  // A transaction that closes a set must start the sweep.
  `MADS_ASSERT_NXT(a_end_starts_sweep, clk_i, rst_ni, in_valid_i && in_ready_o && set_end_i, state == ST_SWEEP, "set end did not start the sweep")

  // A new result appears only out of the result phase.
  `MADS_ASSERT_IMP(a_result_from_done, clk_i, rst_ni, $rose(out_valid_o), $past(state) == ST_DONE, "result shown outside the result phase")

  // Every reported set holds at least one value.
  `MADS_ASSERT_IMP(a_size_nonzero, clk_i, rst_ni, out_valid_o, set_size_o != '0, "result reports an empty set")

endmodule
